FILE: rtl/core/mfbre_pkg.sv
// ----------------------------------------------------------------------------
// mfbre_pkg
// shared types, codes and constants of the frame store raster engine
// ----------------------------------------------------------------------------
package mfbre_pkg;

  localparam int unsigned DefaultRows    = 64;
  localparam int unsigned DefaultColumns = 128;
  localparam int unsigned StoreDepth     = 1024;
  localparam int unsigned StoreAw        = 10;
  localparam int unsigned CmdQueueDepth  = 2;

  typedef enum logic [2:0] {
    ActClear  = 3'd0,
    ActPixel  = 3'd1,
    ActLine   = 3'd2,
    ActRing   = 3'd3,
    ActDisk   = 3'd4,
    ActRead   = 3'd5,
    ActSpare6 = 3'd6,
    ActSpare7 = 3'd7
  } action_e;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] start_row;
    logic [6:0] start_column;
    logic [5:0] end_row;
    logic [6:0] end_column;
    logic [6:0] radius;
  } cmd_t;

  typedef struct packed {
    logic       pixel_value;
    logic [7:0] page_byte;
  } rsp_t;

endpackage

FILE: rtl/core/mono_frame_buffer_raster_engine.sv
// ----------------------------------------------------------------------------
// mono_frame_buffer_raster_engine
// 64x128 monochrome frame store with pixel, line, ring and disk drawing
// ----------------------------------------------------------------------------
// After reset the store is wiped before the first command runs. Each command
// word yields one result word once it passes the two-entry input fifo. A line
// runs one serial 16-bit division per pixel along its longer axis, and a ring
// or disk tests every one of the 8192 screen pixels and plots each hit; all
// commands are bound by the single store port and the scan sequencer, and a
// stalled result word delays the start of the next command.
module mono_frame_buffer_raster_engine #(
  parameter int unsigned SCREEN_ROWS    = mfbre_pkg::DefaultRows,
  parameter int unsigned SCREEN_COLUMNS = mfbre_pkg::DefaultColumns
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mfbre_pkg::cmd_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mfbre_pkg::rsp_t out_data_o
);

  logic            q_valid, q_pop;
  mfbre_pkg::cmd_t q_cmd;

  mfbre_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_cmd_i(in_data_i),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  mfbre_engine #(.ScreenRows(SCREEN_ROWS), .ScreenColumns(SCREEN_COLUMNS)) u_engine (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .out_valid_o, .out_stall_i, .out_rsp_o(out_data_o)
  );

  a_read_byte_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_value == 1'b0 || out_data_o.page_byte != 8'd0))
    else $error("pixel set but page byte zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

FILE: rtl/core/mfbre_ram.sv
// ----------------------------------------------------------------------------
// mfbre_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module mfbre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/mfbre_queue.sv
// ----------------------------------------------------------------------------
// mfbre_queue
// front end: accepts command words into a short fifo for the drawing engine
// ----------------------------------------------------------------------------
module mfbre_queue #(
  parameter int unsigned Depth = mfbre_pkg::CmdQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mfbre_pkg::cmd_t  in_cmd_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output mfbre_pkg::cmd_t  q_cmd_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  mfbre_pkg::cmd_t   buf_q [Depth];
  logic [Aw-1:0]     wr_q, rd_q;
  logic [Aw:0]       cnt_q;
  logic              push, pop;

  assign in_stall_o = (cnt_q == (Aw+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = buf_q[rd_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
      end
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

FILE: rtl/core/mfbre_div.sv
// ----------------------------------------------------------------------------
// mfbre_div
// iterative signed divider, quotient truncated toward zero, one bit a cycle
// ----------------------------------------------------------------------------
module mfbre_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] num_i,
  input  logic signed [7:0]  den_i,
  output logic               done_o,
  output logic signed [15:0] quo_o
);

  logic [15:0] rem_q, quo_q;
  logic [7:0]  den_q;
  logic        neg_q, busy_q;
  logic [4:0]  cnt_q;
  logic [16:0] trial;

  assign trial  = {rem_q, quo_q[15]} - {9'd0, den_q};
  assign done_o = busy_q && (cnt_q == 5'd0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd16;
      rem_q  <= '0;
      quo_q  <= num_i[15] ? 16'(-num_i) : num_i;
      den_q  <= den_i[7] ? 8'(-den_i) : den_i;
      neg_q  <= num_i[15] ^ den_i[7];
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
        if (!trial[16]) begin
          rem_q <= trial[15:0];
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= {rem_q[14:0], quo_q[15]};
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: rtl/core/mfbre_engine.sv
// ----------------------------------------------------------------------------
// mfbre_engine
// back end: sequences each command over the frame store, plotting by read-modify-write
// ----------------------------------------------------------------------------
module mfbre_engine #(
  parameter int unsigned ScreenRows    = mfbre_pkg::DefaultRows,
  parameter int unsigned ScreenColumns = mfbre_pkg::DefaultColumns
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  mfbre_pkg::cmd_t  q_cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mfbre_pkg::rsp_t  out_rsp_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StWipe   = 4'd1;
  localparam logic [3:0] StPlot   = 4'd2;
  localparam logic [3:0] StRead   = 4'd3;
  localparam logic [3:0] StWrite  = 4'd4;
  localparam logic [3:0] StScan   = 4'd5;
  localparam logic [3:0] StSq     = 4'd6;
  localparam logic [3:0] StTest   = 4'd7;
  localparam logic [3:0] StLine   = 4'd8;
  localparam logic [3:0] StDiv    = 4'd9;
  localparam logic [3:0] StRdRet  = 4'd10;
  localparam logic [3:0] StRdWait = 4'd11;
  localparam logic [3:0] StDone   = 4'd12;

  logic [3:0]  st_q;
  mfbre_pkg::cmd_t cmd_q;
  logic [9:0]  idx_q;           // wipe address
  logic signed [8:0] pr_q, pc_q; // pixel to plot
  logic [3:0]  ret_q;           // state to resume after a plot or wipe
  logic        rdflag_q;
  logic        out_valid_q;
  mfbre_pkg::rsp_t rsp_q, res_q;
  logic [13:0] sq_q;
  logic [14:0] dist_q;
  logic        major_col_q;
  logic [6:0]  li_q, lhi_q;
  logic signed [15:0] base_q;
  logic signed [7:0]  lden_q, lstep_q;

  logic        ram_we;
  logic [9:0]  ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;

  mfbre_ram #(.Width(8), .Depth(mfbre_pkg::StoreDepth)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic div_start, div_done;
  logic signed [15:0] div_num, div_quo;
  mfbre_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(lden_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic        onscr;
  logic signed [7:0] r1, c1, r2, c2;
  logic signed [15:0] rd_num;
  logic hit;
  logic done_fire;

  assign onscr = !pr_q[8] && !pc_q[8] && (pr_q < 9'(ScreenRows)) &&
                 (pc_q < 9'(ScreenColumns)) && (pr_q < 9'sd64) && (pc_q < 9'sd128);
  assign r1 = 8'($signed({2'b0, cmd_q.start_row}));
  assign c1 = $signed({1'b0, cmd_q.start_column});
  assign r2 = 8'($signed({2'b0, cmd_q.end_row}));
  assign c2 = $signed({1'b0, cmd_q.end_column});
  assign div_num = base_q + 16'($signed({9'd0, li_q}) * lstep_q);
  assign rd_num = 16'(r1 * (c2 - c1)) + 16'(c1 * (r1 - r2));
  assign hit = (cmd_q.action == mfbre_pkg::ActDisk) ? (dist_q <= 15'(sq_q)) :
               ((dist_q + 15'(cmd_q.radius) >= 15'(sq_q)) &&
                (dist_q <= 15'(sq_q) + 15'(cmd_q.radius)));

  // scan row/column from index: rows 0..63, columns 0..127 over 13 bits
  logic [12:0] sidx_q;
  logic [5:0]  srow;
  logic [6:0]  scol;
  logic signed [7:0] sdr, sdc;
  assign srow = sidx_q[12:7];
  assign scol = sidx_q[6:0];
  assign sdr  = 8'($signed({2'b0, srow})) - r1;
  assign sdc  = $signed({1'b0, scol}) - c1;

  assign q_pop_o     = (st_q == StIdle) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign done_fire   = (st_q == StDone) && (!out_valid_q || !out_stall_i);

  logic [9:0] paddr;
  assign paddr = {pr_q[5:3], pc_q[6:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = paddr;
    ram_wdata = ram_rdata | (8'h01 << pr_q[2:0]);
    div_start = 1'b0;
    unique case (st_q)
      StWipe: begin
        ram_we = 1'b1; ram_addr = idx_q; ram_wdata = 8'h00;
      end
      StWrite: ram_we = 1'b1;
      StLine: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset wipe returns to idle without a word
      st_q <= StWipe; idx_q <= '0; pr_q <= '0; pc_q <= '0; ret_q <= StIdle;
      rdflag_q <= 1'b0; out_valid_q <= 1'b0; rsp_q <= '0; res_q <= '0; sq_q <= '0;
      dist_q <= '0; major_col_q <= 1'b0; li_q <= '0; lhi_q <= '0; base_q <= '0;
      lden_q <= '0; lstep_q <= '0; sidx_q <= '0;
    end else begin
      if (done_fire) begin
        out_valid_q <= 1'b1;
        rsp_q <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: if (q_valid_i) begin
          rdflag_q <= (q_cmd_i.action == mfbre_pkg::ActRead);
          res_q <= '0;
          pr_q <= 9'($signed({3'b0, q_cmd_i.start_row}));
          pc_q <= $signed({2'b0, q_cmd_i.start_column});
          ret_q <= StDone;
          sidx_q <= '0; idx_q <= '0;
          unique case (q_cmd_i.action) inside
            mfbre_pkg::ActClear: st_q <= StWipe;
            mfbre_pkg::ActPixel: st_q <= StPlot;
            mfbre_pkg::ActLine:  st_q <= StScan;
            mfbre_pkg::ActRing, mfbre_pkg::ActDisk: st_q <= StSq;
            mfbre_pkg::ActRead:  st_q <= StPlot;
            default: st_q <= StDone;
          endcase
        end
        StWipe: begin
          idx_q <= idx_q + 10'd1;
          if (idx_q == 10'(mfbre_pkg::StoreDepth - 1)) st_q <= ret_q;
        end
        StPlot: st_q <= onscr ? StRead : ret_q;
        StRead: st_q <= rdflag_q ? StRdRet : StWrite;
        StWrite: st_q <= ret_q;
        StRdRet: begin
          res_q.page_byte <= ram_rdata;
          res_q.pixel_value <= ram_rdata[pr_q[2:0]];
          st_q <= StRdWait;
        end
        StRdWait: st_q <= StDone;
        StSq: begin
          sq_q <= 14'(cmd_q.radius * cmd_q.radius);
          dist_q <= 15'(sdr * sdr) + 15'(sdc * sdc);
          st_q <= StTest;
        end
        StTest: begin
          // pixel of sidx_q tested; plot on a hit, then advance
          pr_q <= 9'($signed({3'b0, srow}));
          pc_q <= $signed({2'b0, scol});
          ret_q <= (sidx_q == 13'h1fff) ? StDone : StSq;
          sidx_q <= sidx_q + 13'd1;
          st_q <= hit ? StPlot : ((sidx_q == 13'h1fff) ? StDone : StSq);
        end
        StScan: begin
          // set up the line, StScan runs once per command
          if ((((c1 > c2) ? c1 - c2 : c2 - c1) >= ((r1 > r2) ? r1 - r2 : r2 - r1))
              && (c1 != c2)) begin
            major_col_q <= 1'b1;
            li_q <= 7'((c1 < c2) ? c1 : c2); lhi_q <= 7'((c1 < c2) ? c2 : c1);
            lden_q <= c2 - c1; lstep_q <= r2 - r1; base_q <= rd_num;
            st_q <= StLine;
          end else if (r1 != r2) begin
            major_col_q <= 1'b0;
            li_q <= 7'((r1 < r2) ? r1 : r2); lhi_q <= 7'((r1 < r2) ? r2 : r1);
            lden_q <= r1 - r2; lstep_q <= c1 - c2; base_q <= rd_num;
            st_q <= StLine;
          end else begin
            st_q <= StDone;
          end
        end
        StLine: st_q <= StDiv;
        StDiv: if (div_done) begin
          if (major_col_q) begin
            pr_q <= 9'(div_quo); pc_q <= $signed({2'b0, li_q});
          end else begin
            pr_q <= $signed({2'b0, li_q}); pc_q <= 9'(div_quo);
          end
          ret_q <= (li_q == lhi_q) ? StDone : StLine;
          li_q <= li_q + 7'd1;
          st_q <= StPlot;
        end
        StDone: if (done_fire) begin
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: test/mono_frame_buffer_raster_engine_test.sv
// ----------------------------------------------------------------------------
// mono_frame_buffer_raster_engine_test
// drives clear, pixel, line, ring, disk and read commands through the raster
// engine, tracks the frame store in a local model and checks every result word
// ----------------------------------------------------------------------------
module mono_frame_buffer_raster_engine_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rows = 64;
  localparam int Cols = 128;
  localparam int IdleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  mfbre_pkg::cmd_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  mfbre_pkg::rsp_t out_data_o;

  mono_frame_buffer_raster_engine DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  logic [7:0] pages [1024];
  mfbre_pkg::cmd_t pending_cmds [$];
  mfbre_pkg::rsp_t expected_rsps [$];
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_sender;
  int errors;
  int idle_cycles;
  int words_in;
  int words_out;
  bit timed_out;
  int act_count [8];

  function automatic bit on_screen(int row, int col);
    return row >= 0 && row < Rows && col >= 0 && col < Cols;
  endfunction

  function automatic void plot(int row, int col);
    if (on_screen(row, col)) pages[(row >> 3) * Cols + col][row & 7] = 1'b1;
  endfunction

  function automatic void draw_line(int r1, int c1, int r2, int c2);
    int clo, chi, rlo, rhi;
    clo = c1 <= c2 ? c1 : c2;
    chi = c1 <= c2 ? c2 : c1;
    rlo = r1 <= r2 ? r1 : r2;
    rhi = r1 <= r2 ? r2 : r1;
    // signed int division truncates toward zero like the hardware divider
    if (chi - clo >= rhi - rlo && c2 != c1) begin
      for (int i = clo; i <= chi; i++)
        plot((i * (r2 - r1) + r1 * (c2 - c1) + c1 * (r1 - r2)) / (c2 - c1), i);
    end else if (r1 != r2) begin
      for (int i = rlo; i <= rhi; i++)
        plot(i, (i * (c1 - c2) + r1 * (c2 - c1) + c1 * (r1 - r2)) / (r1 - r2));
    end
  endfunction

  function automatic void draw_round(int crow, int ccol, int rad, bit filled);
    int d, sq;
    sq = rad * rad;
    for (int r = 0; r < Rows; r++)
      for (int c = 0; c < Cols; c++) begin
        d = (c - ccol) * (c - ccol) + (r - crow) * (r - crow);
        if (filled ? (d <= sq) : (d >= sq - rad && d <= sq + rad)) plot(r, c);
      end
  endfunction

  function automatic mfbre_pkg::rsp_t apply_command(mfbre_pkg::cmd_t cmd);
    mfbre_pkg::rsp_t rsp;
    logic [7:0] b;
    rsp = '0;
    case (mfbre_pkg::action_e'(cmd.action))
      mfbre_pkg::ActClear: begin
        foreach (pages[i]) pages[i] = '0;
      end
      mfbre_pkg::ActPixel: plot(cmd.start_row, cmd.start_column);
      mfbre_pkg::ActLine:
        draw_line(cmd.start_row, cmd.start_column, cmd.end_row, cmd.end_column);
      mfbre_pkg::ActRing: draw_round(cmd.start_row, cmd.start_column, cmd.radius, 1'b0);
      mfbre_pkg::ActDisk: draw_round(cmd.start_row, cmd.start_column, cmd.radius, 1'b1);
      mfbre_pkg::ActRead: begin
        b = pages[(cmd.start_row >> 3) * Cols + cmd.start_column];
        rsp.pixel_value = b[cmd.start_row[2:0]];
        rsp.page_byte = b;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic mfbre_pkg::cmd_t make_cmd(mfbre_pkg::action_e act, int sr, int sc,
                                               int er, int ec, int rad);
    mfbre_pkg::cmd_t cmd;
    cmd.action = act;
    cmd.start_row = 6'(sr);
    cmd.start_column = 7'(sc);
    cmd.end_row = 6'(er);
    cmd.end_column = 7'(ec);
    cmd.radius = 7'(rad);
    return cmd;
  endfunction

  // draws and reads at random points, a few clears and spare actions; big radii are rare
  function automatic mfbre_pkg::cmd_t random_cmd();
    mfbre_pkg::cmd_t cmd;
    int pick;
    cmd = mfbre_pkg::cmd_t'(36'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 3) cmd.action = mfbre_pkg::ActClear;
    else if (pick < 18) cmd.action = mfbre_pkg::ActPixel;
    else if (pick < 36) cmd.action = mfbre_pkg::ActLine;
    else if (pick < 46) cmd.action = mfbre_pkg::ActRing;
    else if (pick < 54) cmd.action = mfbre_pkg::ActDisk;
    else if (pick < 96) cmd.action = mfbre_pkg::ActRead;
    else cmd.action = 3'($urandom_range(mfbre_pkg::ActSpare6, mfbre_pkg::ActSpare7));
    if (cmd.action == mfbre_pkg::ActLine && $urandom_range(0, 3) == 0) begin
      cmd.end_row = 6'(int'(cmd.start_row) + int'($urandom_range(0, 6)) - 3);
      cmd.end_column = 7'(int'(cmd.start_column) + int'($urandom_range(0, 6)) - 3);
    end
    if ((cmd.action == mfbre_pkg::ActRing || cmd.action == mfbre_pkg::ActDisk) &&
        $urandom_range(0, 4) != 0)
      cmd.radius = 7'($urandom_range(0, 12));
    return cmd;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(apply_command(in_data_i));
        act_count[in_data_i.action]++;
        words_in++;
        void'(pending_cmds.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled word
      end else if (pending_cmds.size() != 0 && !hold_sender &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_cmds[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_data_o);
          errors++;
        end else begin
          mfbre_pkg::rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (out_data_o.pixel_value !== exp_rsp.pixel_value) begin
            $display("%0t: pixel_value expected %0h actual %0h", $time,
                     exp_rsp.pixel_value, out_data_o.pixel_value);
            errors++;
          end
          if (out_data_o.page_byte !== exp_rsp.page_byte) begin
            $display("%0t: page_byte expected %02h actual %02h", $time,
                     exp_rsp.page_byte, out_data_o.page_byte);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    mfbre_pkg::cmd_t cmd;
    int n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_sender = 1'b0;
    errors = 0;
    idle_cycles = 0;
    words_in = 0;
    words_out = 0;
    timed_out = 1'b0;
    foreach (pages[i]) pages[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        wait (idle_cycles >= IdleLimit);
        timed_out = 1'b1;
      end
      begin
        send_idle_pct = 34;
        recv_idle_pct = 74;
        // corners, every action, edge cases
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActPixel, 0, 0, 63, 127, 127));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActPixel, 63, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 63, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 1, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActLine, 10, 20, 10, 20, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 10, 20, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActLine, 0, 127, 63, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 32, 63, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActLine, 63, 5, 2, 9, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 40, 7, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRing, 20, 40, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 20, 40, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRing, 30, 60, 0, 0, 10));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 20, 60, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActDisk, 0, 0, 0, 0, 127));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 63, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActSpare6, 63, 127, 63, 127, 127));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActSpare7, 5, 5, 5, 5, 5));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActClear, 63, 127, 63, 127, 127));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 63, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActDisk, 63, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbre_pkg::ActRead, 63, 127, 0, 0, 0));
        wait_drained();
        // once the engine has drained, the sender is held off before the random phases
        hold_sender = 1'b1;
        repeat (20) @(posedge clk_i);
        hold_sender = 1'b0;
        for (int phase = 0; phase < 3; phase++) begin
          send_idle_pct = phase == 0 ? 34 : phase == 1 ? 74 : 0;
          recv_idle_pct = phase == 0 ? 74 : phase == 1 ? 34 : 0;
          n = phase == 2 ? 26 : 25;
          for (int k = 0; k < n; k++) begin
            cmd = random_cmd();
            pending_cmds.push_back(cmd);
          end
          wait_drained();
        end
        repeat (50) @(posedge clk_i);
      end
    join_any

    if (timed_out) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("mono_frame_buffer_raster_engine_test: done, errors");
    end else begin
      $display("%0d commands in, %0d results out, %0d reads, %0d lines, %0d rings, %0d disks",
               words_in, words_out, act_count[mfbre_pkg::ActRead],
               act_count[mfbre_pkg::ActLine], act_count[mfbre_pkg::ActRing],
               act_count[mfbre_pkg::ActDisk]);
      if (errors == 0 && expected_rsps.size() == 0) begin
        $display("mono_frame_buffer_raster_engine_test: done, clean");
      end else begin
        $display("mono_frame_buffer_raster_engine_test: done, errors");
      end
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mfbre_pkg.sv
rtl/core/mfbre_ram.sv
rtl/core/mfbre_queue.sv
rtl/core/mfbre_div.sv
rtl/core/mfbre_engine.sv
rtl/core/mono_frame_buffer_raster_engine.sv
test/mono_frame_buffer_raster_engine_test.sv
